[hdl/uti_pkg.sv]
// shared constants, codes and types of the uniform table interpolator
`default_nettype none

package uti_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int FRAC_BITS   = 16;
  localparam int DATA_W      = 32;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int ENTRY_W     = 10;
  localparam int LAST_W      = 10;
  localparam int CMD_W       = 2;
  localparam int MODE_W      = 2;
  localparam int REG_W       = 2;
  localparam int LAST_MIN    = 2;

  localparam int PROD_W  = 2 * DATA_W;
  localparam int NI_W    = PROD_W - 2 * FRAC_BITS;
  localparam int DIFF_W  = DATA_W + 1;
  localparam int A_W     = DIFF_W + NI_W + 1;
  localparam int B_W     = DIFF_W + FRAC_BITS + 1;
  localparam int CLAMP_W = DATA_W + 4;
  localparam int SUM_W   = DATA_W + 6;

  localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_STEP   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LINEAR = 2'd2;

  localparam logic [MODE_W-1:0] MODE_ZERO = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LAST = 2'd2;

  localparam logic [REG_W-1:0] REG_GRID_START  = 2'd0;
  localparam logic [REG_W-1:0] REG_GRID_END    = 2'd1;
  localparam logic [REG_W-1:0] REG_INV_SPACING = 2'd2;
  localparam logic [REG_W-1:0] REG_LAST_INDEX  = 2'd3;

  typedef enum logic [1:0] {
    KIND_ZERO  = 2'd0,
    KIND_ENTRY = 2'd1,
    KIND_LERP  = 2'd2
  } kind_t;

  typedef struct packed {
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr_a;
    logic [IDX_W-1:0]  rd_addr_b;
  } tbl_req_t;

endpackage

`default_nettype wire

[hdl/uniform_table_interpolator.sv]
// top level: config registers, seven-stage lookup and interpolation pipeline
// seven register stages, from the stage that accepts a request to the output register
// throughput: one request per cycle while in_stall is low; loads and unused commands give no result
// the 32x32 index multiply and the 33x32 slope multiply each take a stage
// reset sets config registers to defaults and clears stage valid bits; the table is not cleared
`default_nettype none

module uniform_table_interpolator (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [uti_pkg::REG_W-1:0]   cfg_index,
  input  logic [uti_pkg::DATA_W-1:0]  cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [uti_pkg::CMD_W-1:0]   cmd,
  input  logic signed [uti_pkg::DATA_W-1:0] abscissa,
  input  logic [uti_pkg::MODE_W-1:0]  extrap_mode,
  input  logic [uti_pkg::ENTRY_W-1:0] entry_index,
  input  logic signed [uti_pkg::DATA_W-1:0] entry_value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [uti_pkg::DATA_W-1:0] result_value,
  output logic                        saturated
);
  import uti_pkg::*;

  localparam logic signed [CLAMP_W-1:0] A_LIM = {2'b01, {(CLAMP_W-2){1'b0}}};
  localparam logic signed [SUM_W-1:0] RES_MAX =
    SUM_W'({1'b0, {(DATA_W-1){1'b1}}});
  localparam logic signed [SUM_W-1:0] RES_MIN = ~RES_MAX;

  // config registers
  logic signed [DATA_W-1:0] grid_start;
  logic signed [DATA_W-1:0] grid_end;
  logic [DATA_W-1:0]        inv_spacing;
  logic [LAST_W-1:0]        last_index;
  logic [LAST_W-1:0]        last_lo;
  logic [IDX_W-1:0]         l_eff;
  logic [IDX_W-1:0]         l_m1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_start  <= '0;
      grid_end    <= '0;
      inv_spacing <= DATA_W'(1) << FRAC_BITS;
      last_index  <= LAST_W'(LAST_MIN);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_GRID_START:  grid_start  <= cfg_data;
        REG_GRID_END:    grid_end    <= cfg_data;
        REG_INV_SPACING: inv_spacing <= cfg_data;
        REG_LAST_INDEX:  last_index  <= cfg_data[LAST_W-1:0];
      endcase
    end
  end

  always_comb begin
    last_lo = (last_index < LAST_W'(LAST_MIN)) ? LAST_W'(LAST_MIN) : last_index;
    if (32'(last_lo) > 32'(TABLE_DEPTH - 1)) begin
      l_eff = IDX_W'(TABLE_DEPTH - 1);
    end else begin
      l_eff = IDX_W'(last_lo);
    end
    l_m1 = l_eff - IDX_W'(1);
  end

  // handshake: a stage takes new data when it is empty or its data moves on
  logic v1, v2, v3, v4, v5, v6, v7;
  logic r1, r2, r3, r4, r5, r6, r7;

  assign r7 = !v7 || !out_stall;
  assign r6 = !v6 || r7;
  assign r5 = !v5 || r6;
  assign r4 = !v4 || r5;
  assign r3 = !v3 || r4;
  assign r2 = !v2 || r3;
  assign r1 = !v1 || r2;
  assign in_stall = !r1;

  // stage 1: offset from grid start, range flags
  logic signed [DIFF_W-1:0] d_in;
  logic                     cmd_ok;
  logic [DATA_W-1:0]        d1;
  logic                     below1, beyond1;
  logic [CMD_W-1:0]         cmd1;
  logic [MODE_W-1:0]        mode1;
  logic [IDX_W-1:0]         idx1;
  logic [DATA_W-1:0]        val1;

  assign d_in = DIFF_W'(abscissa) - DIFF_W'(grid_start);
  assign cmd_ok = (cmd == CMD_STEP) || (cmd == CMD_LINEAR) ||
                  ((cmd == CMD_LOAD) && (32'(entry_index) < 32'(TABLE_DEPTH)));

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (r1) begin
      v1 <= in_valid && cmd_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (r1) begin
      d1      <= d_in[DATA_W-1:0];
      below1  <= d_in[DIFF_W-1];
      beyond1 <= abscissa > grid_end;
      cmd1    <= cmd;
      mode1   <= extrap_mode;
      idx1    <= IDX_W'(entry_index);
      val1    <= entry_value;
    end
  end

  // stage 2: scaled index product
  logic [PROD_W-1:0] p2;
  logic              below2, beyond2;
  logic [CMD_W-1:0]  cmd2;
  logic [MODE_W-1:0] mode2;
  logic [IDX_W-1:0]  idx2;
  logic [DATA_W-1:0] val2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (r2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (r2) begin
      p2      <= PROD_W'(d1) * PROD_W'(inv_spacing);
      below2  <= below1;
      beyond2 <= beyond1;
      cmd2    <= cmd1;
      mode2   <= mode1;
      idx2    <= idx1;
      val2    <= val1;
    end
  end

  // stage 3: table addresses and interpolation weight
  logic [NI_W+1:0]     step_sum;
  logic [NI_W:0]       n_step;
  logic [IDX_W-1:0]    step_addr;
  logic [NI_W-1:0]     n_raw;
  logic [IDX_W-1:0]    n_lin;
  kind_t               kind_next;
  logic [IDX_W-1:0]    addr_a_next;

  assign step_sum  = {1'b0, p2[PROD_W-1:2*FRAC_BITS-1]} + (NI_W+2)'(1);
  assign n_step    = step_sum[NI_W+1:1];
  assign step_addr = (n_step > (NI_W+1)'(l_eff)) ? l_eff : n_step[IDX_W-1:0];
  assign n_raw     = p2[PROD_W-1:2*FRAC_BITS];
  assign n_lin     = (n_raw > NI_W'(l_m1)) ? l_m1 : n_raw[IDX_W-1:0];

  always_comb begin
    kind_next   = KIND_LERP;
    addr_a_next = n_lin;
    if (below2) begin
      kind_next = KIND_ZERO;
    end else if (cmd2 == CMD_STEP) begin
      kind_next   = KIND_ENTRY;
      addr_a_next = step_addr;
    end else if (beyond2 && (mode2 == MODE_ZERO)) begin
      kind_next = KIND_ZERO;
    end else if (beyond2 && (mode2 == MODE_LAST)) begin
      kind_next   = KIND_ENTRY;
      addr_a_next = l_eff;
    end
  end

  logic                 load3;
  kind_t                kind3;
  logic [IDX_W-1:0]     addr_a3, addr_b3;
  logic [NI_W-1:0]      rh3;
  logic [FRAC_BITS-1:0] rl3;
  logic [IDX_W-1:0]     idx3;
  logic [DATA_W-1:0]    val3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (r3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (r3) begin
      load3   <= cmd2 == CMD_LOAD;
      kind3   <= kind_next;
      addr_a3 <= addr_a_next;
      addr_b3 <= n_lin + IDX_W'(1);
      rh3     <= n_raw - NI_W'(n_lin);
      rl3     <= p2[2*FRAC_BITS-1:FRAC_BITS];
      idx3    <= idx2;
      val3    <= val2;
    end
  end

  // stage 4: table read; loads write here so order with lookups is kept
  tbl_req_t             tbl_req;
  logic [DATA_W-1:0]    rd_a, rd_b;
  kind_t                kind4;
  logic [NI_W-1:0]      rh4;
  logic [FRAC_BITS-1:0] rl4;

  assign tbl_req.wr_en     = v3 && load3 && r4;
  assign tbl_req.wr_addr   = idx3;
  assign tbl_req.wr_data   = val3;
  assign tbl_req.rd_en     = r4;
  assign tbl_req.rd_addr_a = addr_a3;
  assign tbl_req.rd_addr_b = addr_b3;

  uti_table u_table (
    .clk       (clk),
    .req       (tbl_req),
    .rd_data_a (rd_a),
    .rd_data_b (rd_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (r4) begin
      v4 <= v3 && !load3;
    end
  end

  always_ff @(posedge clk) begin
    if (r4) begin
      kind4 <= kind3;
      rh4   <= rh3;
      rl4   <= rl3;
    end
  end

  // stage 5: slope between neighbors
  logic signed [DIFF_W-1:0] diff5;
  logic signed [DATA_W-1:0] v0_5;
  kind_t                    kind5;
  logic [NI_W-1:0]          rh5;
  logic [FRAC_BITS-1:0]     rl5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (r5) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (r5) begin
      diff5 <= DIFF_W'($signed(rd_b)) - DIFF_W'($signed(rd_a));
      v0_5  <= rd_a;
      kind5 <= kind4;
      rh5   <= rh4;
      rl5   <= rl4;
    end
  end

  // stage 6: slope times whole and fractional part of the weight
  logic signed [A_W-1:0]    a6;
  logic signed [B_W-1:0]    b6;
  logic signed [DATA_W-1:0] v0_6;
  kind_t                    kind6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (r6) begin
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (r6) begin
      a6    <= A_W'(diff5) * A_W'($signed({1'b0, rh5}));
      b6    <= B_W'(diff5) * B_W'($signed({1'b0, rl5}));
      v0_6  <= v0_5;
      kind6 <= kind5;
    end
  end

  // stage 7: sum, saturate, output register
  logic signed [CLAMP_W-1:0]         a_cl;
  logic signed [B_W-FRAC_BITS-1:0]   b_sh;
  logic signed [B_W-1:0]             b_shift;
  logic signed [SUM_W-1:0]           sum;
  logic signed [DATA_W-1:0]          res_next;
  logic                              sat_next;

  always_comb begin
    if (a6 > A_LIM) begin
      a_cl = A_LIM;
    end else if (a6 < -A_LIM) begin
      a_cl = -A_LIM;
    end else begin
      a_cl = a6[CLAMP_W-1:0];
    end
    b_shift = b6 >>> FRAC_BITS;
    b_sh    = b_shift[B_W-FRAC_BITS-1:0];
    sum     = SUM_W'(v0_6) + SUM_W'(a_cl) + SUM_W'(b_sh);
    res_next = '0;
    sat_next = 1'b0;
    unique case (kind6)
      KIND_ZERO: begin
        res_next = '0;
      end
      KIND_ENTRY: begin
        res_next = v0_6;
      end
      KIND_LERP: begin
        if (sum > RES_MAX) begin
          res_next = RES_MAX[DATA_W-1:0];
          sat_next = 1'b1;
        end else if (sum < RES_MIN) begin
          res_next = RES_MIN[DATA_W-1:0];
          sat_next = 1'b1;
        end else begin
          res_next = sum[DATA_W-1:0];
        end
      end
      default: begin
        res_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else if (r7) begin
      v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (r7) begin
      result_value <= res_next;
      saturated    <= sat_next;
    end
  end

  assign out_valid = v7;

endmodule

`default_nettype wire

[hdl/uti_table.sv]
// sample table: one write port, two registered read ports
`default_nettype none

module uti_table (
  input  logic                     clk,
  input  uti_pkg::tbl_req_t        req,
  output logic [uti_pkg::DATA_W-1:0] rd_data_a,
  output logic [uti_pkg::DATA_W-1:0] rd_data_b
);
  import uti_pkg::*;

  logic [DATA_W-1:0] mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_a <= mem[req.rd_addr_a];
      rd_data_b <= mem[req.rd_addr_b];
    end
  end

endmodule

`default_nettype wire

[hdl/uti_checker.sv]
// port-level checks of the uniform table interpolator, bound to the top level
`default_nettype none

module uti_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [uti_pkg::DATA_W-1:0] result_value,
  input logic                       saturated
);
  import uti_pkg::*;

  localparam logic [DATA_W-1:0] POS_LIM = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] NEG_LIM = {1'b1, {(DATA_W-1){1'b0}}};

  // held result stays on the port
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(result_value) && $stable(saturated))
    else $error("result changed while stalled");

  // input is held off only when the whole pipeline is full and blocked
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with room in the pipeline");

  // clipped results sit exactly at a range limit
  a_sat_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |-> (result_value == POS_LIM) || (result_value == NEG_LIM))
    else $error("saturated flag without a limit value");

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

endmodule

bind uniform_table_interpolator uti_checker u_checker (.*);

`default_nettype wire

[test/uniform_table_interpolator_test.sv]
// self-checking testbench for the uniform table interpolator: random requests, stalls, checks
`timescale 1ns / 100ps

module uniform_table_interpolator_test;
  import uti_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam logic [MODE_W-1:0] MODE_EXTRAP = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
  localparam int DRAIN_CYCLES = 16;
  localparam int HOLD_CYCLES = 250;
  localparam int CYCLE_LIMIT = 600000;
  localparam int MAX_PRINTED = 100;
  localparam logic [127:0] Q_LIMIT = 128'd1 << 40;

  typedef struct {
    logic [CMD_W-1:0] cmd;
    logic signed [DATA_W-1:0] abscissa;
    logic [MODE_W-1:0] mode;
    logic [ENTRY_W-1:0] idx;
    logic signed [DATA_W-1:0] value;
  } lookup_req_t;

  typedef struct {
    logic [DATA_W-1:0] value;
    logic sat;
  } lookup_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [REG_W-1:0] cfg_index = '0;
  logic [DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [CMD_W-1:0] cmd = '0;
  logic signed [DATA_W-1:0] abscissa = '0;
  logic [MODE_W-1:0] extrap_mode = '0;
  logic [ENTRY_W-1:0] entry_index = '0;
  logic signed [DATA_W-1:0] entry_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [DATA_W-1:0] result_value;
  logic saturated;

  // register copies and table copy
  logic signed [DATA_W-1:0] start_reg = '0;
  logic signed [DATA_W-1:0] end_reg = '0;
  logic [DATA_W-1:0] inv_reg = 32'd65536;
  logic [LAST_W-1:0] last_reg = LAST_W'(LAST_MIN);
  logic signed [DATA_W-1:0] sample_copy [TABLE_DEPTH];
  bit written [TABLE_DEPTH];

  lookup_req_t requests_to_send [$];
  lookup_res_t lookup_results_due [$];
  lookup_req_t next_req;

  bit idle_on = 1'b1;
  bit holding = 1'b0;
  bit pressure_done = 1'b0;
  int send_gap = 0;
  int recv_gap = 0;
  int hold_left = 0;
  int cycle_count = 0;
  int error_count = 0;
  int lookups_seen = 0;
  int loads_seen = 0;
  int checked_count = 0;
  int sat_count = 0;
  int settings_count = 0;

  uniform_table_interpolator DUT (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .cmd(cmd),
    .abscissa(abscissa),
    .extrap_mode(extrap_mode),
    .entry_index(entry_index),
    .entry_value(entry_value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .result_value(result_value),
    .saturated(saturated)
  );

  always #6 clk = ~clk;

  function automatic int unsigned eff_last();
    return (last_reg < LAST_MIN) ? LAST_MIN : last_reg;
  endfunction

  function automatic logic [63:0] scaled_offset(input logic signed [DATA_W-1:0] x);
    logic [DATA_W:0] d;
    d = {x[DATA_W-1], x} - {start_reg[DATA_W-1], start_reg};
    return {32'd0, d[DATA_W-1:0]} * {32'd0, inv_reg};
  endfunction

  // table entries a lookup reads; equal indices mean a plain entry result
  function automatic void entries_read(input lookup_req_t rq, output bit hit,
                                       output int unsigned ia, output int unsigned ib);
    logic [63:0] p, n;
    int unsigned l;
    hit = 1'b0;
    ia = 0;
    ib = 0;
    l = eff_last();
    if ((rq.cmd == CMD_STEP || rq.cmd == CMD_LINEAR) && rq.abscissa >= start_reg) begin
      p = scaled_offset(rq.abscissa);
      hit = 1'b1;
      if (rq.cmd == CMD_STEP) begin
        n = ((p >> (2 * FRAC_BITS - 1)) + 64'd1) >> 1;
        ia = (n > l) ? l : int'(n);
        ib = ia;
      end else if (rq.abscissa > end_reg && rq.mode == MODE_ZERO) begin
        hit = 1'b0;
      end else if (rq.abscissa > end_reg && rq.mode == MODE_LAST) begin
        ia = l;
        ib = l;
      end else begin
        n = p >> (2 * FRAC_BITS);
        if (n > l - 1) n = l - 1;
        ia = int'(n);
        ib = ia + 1;
      end
    end
  endfunction

  function automatic lookup_res_t interpolated_result(input lookup_req_t rq);
    lookup_res_t res;
    logic [63:0] p, r, mag;
    logic [127:0] prod, q;
    longint v0, diff, sum;
    bit hit, neg;
    int unsigned ia, ib;
    res.value = '0;
    res.sat = 1'b0;
    entries_read(rq, hit, ia, ib);
    if (!hit) return res;
    if (ia == ib) begin
      res.value = sample_copy[ia];
      return res;
    end
    p = scaled_offset(rq.abscissa);
    r = (p >> FRAC_BITS) - (64'(ia) << FRAC_BITS);
    v0 = sample_copy[ia];
    diff = longint'(sample_copy[ib]) - v0;
    neg = diff < 0;
    mag = neg ? -diff : diff;
    prod = {64'd0, mag} * {64'd0, r};
    q = prod >> FRAC_BITS;
    if (neg && prod[FRAC_BITS-1:0] != '0) q = q + 128'd1;
    if (q > Q_LIMIT) q = Q_LIMIT;
    sum = neg ? v0 - longint'(q[63:0]) : v0 + longint'(q[63:0]);
    if (sum > 64'sd2147483647) begin
      sum = 64'sd2147483647;
      res.sat = 1'b1;
    end else if (sum < -64'sd2147483648) begin
      sum = -64'sd2147483648;
      res.sat = 1'b1;
    end
    res.value = sum[DATA_W-1:0];
    return res;
  endfunction

  function automatic logic [DATA_W-1:0] rand_value();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2, 3: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] rand_abscissa();
    longint lo, hi, span, v;
    logic [63:0] rnd;
    logic signed [DATA_W-1:0] raw;
    lo = start_reg;
    hi = end_reg;
    if (hi < lo) hi = lo;
    span = hi - lo;
    rnd = {$urandom, $urandom};
    raw = $urandom;
    case ($urandom_range(0, 9))
      0: v = raw;
      1: v = lo - longint'(rnd % 64'd131072);
      2: v = lo;
      3: v = hi;
      4: v = hi + longint'(rnd % (unsigned'(span) / 4 + 64'd65537));
      default: v = lo + longint'(rnd % (unsigned'(span) + 64'd1));
    endcase
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[DATA_W-1:0];
  endfunction

  function automatic lookup_req_t make_req(input logic [CMD_W-1:0] c,
                                           input logic [DATA_W-1:0] x,
                                           input logic [MODE_W-1:0] m,
                                           input logic [ENTRY_W-1:0] i,
                                           input logic [DATA_W-1:0] v);
    lookup_req_t rq;
    rq.cmd = c;
    rq.abscissa = x;
    rq.mode = m;
    rq.idx = i;
    rq.value = v;
    return rq;
  endfunction

  function automatic lookup_req_t rand_req();
    lookup_req_t rq;
    int unsigned pick;
    rq = make_req(CMD_LINEAR, rand_abscissa(), MODE_W'($urandom_range(0, 3)),
                  ENTRY_W'($urandom_range(0, TABLE_DEPTH - 1)), rand_value());
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      rq.cmd = CMD_LOAD;
      if (pick < 11) rq.idx = ENTRY_W'($urandom_range(0, eff_last()));
    end else if (pick < 17) begin
      rq.cmd = CMD_UNUSED;
    end else if (pick < 55) begin
      rq.cmd = CMD_STEP;
    end
    return rq;
  endfunction

  function automatic void queue_load(input int unsigned idx);
    requests_to_send.push_back(make_req(CMD_LOAD, $urandom, MODE_W'($urandom_range(0, 3)),
                                        ENTRY_W'(idx), rand_value()));
    written[idx] = 1'b1;
  endfunction

  // entries a lookup would read get loaded first when they were never written
  function automatic void push_req(input lookup_req_t rq);
    bit hit;
    int unsigned ia, ib;
    if (rq.cmd == CMD_STEP || rq.cmd == CMD_LINEAR) begin
      entries_read(rq, hit, ia, ib);
      if (hit && !written[ia]) queue_load(ia);
      if (hit && !written[ib]) queue_load(ib);
    end else if (rq.cmd == CMD_LOAD) begin
      written[rq.idx] = 1'b1;
    end
    requests_to_send.push_back(rq);
  endfunction

  task automatic report(input string msg);
    if (error_count < MAX_PRINTED) $display("mismatch: %s", msg);
    error_count++;
  endtask

  task automatic write_reg(input logic [REG_W-1:0] idx, input logic [DATA_W-1:0] data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_GRID_START: start_reg = data;
      REG_GRID_END: end_reg = data;
      REG_INV_SPACING: inv_reg = data;
      REG_LAST_INDEX: last_reg = data[LAST_W-1:0];
      default: ;
    endcase
  endtask

  task automatic program_grid(input logic [DATA_W-1:0] xs, input logic [DATA_W-1:0] xe,
                              input logic [DATA_W-1:0] inv, input int unsigned lreg);
    logic [DATA_W-1:0] data;
    data = $urandom;
    data[LAST_W-1:0] = lreg;
    write_reg(REG_GRID_START, xs);
    write_reg(REG_GRID_END, xe);
    write_reg(REG_INV_SPACING, inv);
    write_reg(REG_LAST_INDEX, data);
    settings_count++;
  endtask

  task automatic setup_phase(input int phase, output int count);
    logic [DATA_W-1:0] spacing, xs, xe, inv;
    int unsigned lreg, leff;
    longint e;
    bit fixed_end;
    spacing = $urandom_range(1 << 12, 1 << 20);
    inv = 32'hFFFF_FFFF / spacing;
    xs = $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
    lreg = $urandom_range(3, 12);
    fixed_end = 1'b0;
    xe = '0;
    count = 200;
    idle_on = 1'b1;
    case (phase)
      0: count = 260;
      1: begin
        xs = 32'h8000_0000;
        xe = 32'h7FFF_FFFF;
        inv = 32'hFFFF_FFFF;
        lreg = 0;
        fixed_end = 1'b1;
        count = 150;
      end
      2: begin
        xs = 32'h7FFF_FFFF;
        xe = 32'h8000_0000;
        inv = '0;
        lreg = 1;
        fixed_end = 1'b1;
        count = 100;
      end
      3: begin
        lreg = $urandom_range(2, 40);
        inv = $urandom;
      end
      4: begin
        idle_on = 1'b0;
        count = 150;
      end
      5: begin
        lreg = TABLE_DEPTH - 1;
        count = 150;
      end
      6: xs = 32'h8000_0000 + $urandom_range(0, 1 << 20);
      default: begin
        idle_on = 1'b0;
        lreg = $urandom_range(3, 20);
      end
    endcase
    if (!fixed_end) begin
      leff = (lreg < LAST_MIN) ? LAST_MIN : lreg;
      e = longint'(signed'(xs)) + longint'(leff) * longint'(spacing);
      if (e > 64'sd2147483647) e = 64'sd2147483647;
      xe = e[DATA_W-1:0];
    end
    program_grid(xs, xe, inv, lreg);
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (requests_to_send.size() != 0 || in_valid || lookup_results_due.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic check_result();
    lookup_res_t want;
    if (lookup_results_due.size() == 0) begin
      report($sformatf("result %h with no lookup outstanding", result_value));
      return;
    end
    want = lookup_results_due.pop_front();
    checked_count++;
    if (want.sat) sat_count++;
    if (result_value !== want.value)
      report($sformatf("result %0d: value %h, expected %h", checked_count, result_value,
                       want.value));
    if (saturated !== want.sat)
      report($sformatf("result %0d: saturated %b, expected %b", checked_count, saturated,
                       want.sat));
  endtask

  task automatic record_request();
    lookup_req_t rq;
    rq = make_req(cmd, abscissa, extrap_mode, entry_index, entry_value);
    if (rq.cmd == CMD_LOAD) begin
      sample_copy[rq.idx] = rq.value;
      loads_seen++;
    end else if (rq.cmd == CMD_STEP || rq.cmd == CMD_LINEAR) begin
      lookup_results_due.push_back(interpolated_result(rq));
      lookups_seen++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (requests_to_send.size() != 0) begin
        next_req = requests_to_send.pop_front();
        cmd <= next_req.cmd;
        abscissa <= next_req.abscissa;
        extrap_mode <= next_req.mode;
        entry_index <= next_req.idx;
        entry_value <= next_req.value;
        in_valid <= 1'b1;
        if (idle_on && !holding && $urandom_range(0, 9) == 0) send_gap = $urandom_range(1, 15);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    bit stall_next;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) check_result();
      if (in_valid && !in_stall) record_request();
      stall_next = 1'b0;
      // one long hold-off so that the pipeline fills and backs up
      if (!pressure_done && lookups_seen >= 100) begin
        hold_left = HOLD_CYCLES;
        pressure_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        stall_next = 1'b1;
      end else if (recv_gap > 0) begin
        recv_gap--;
        stall_next = 1'b1;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        recv_gap = $urandom_range(0, 14);
        stall_next = 1'b1;
      end
      out_stall <= stall_next;
      holding <= (hold_left > 0);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int count;
    rst = 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    program_grid(32'd0, 32'h0004_0000, 32'd65536, 4);
    @(negedge clk);
    push_req(make_req(CMD_LOAD, 32'd0, MODE_EXTRAP, 10'd0, 32'd0));
    push_req(make_req(CMD_LOAD, 32'd0, MODE_EXTRAP, 10'd1, 32'h7FFF_FFFF));
    push_req(make_req(CMD_LOAD, 32'd0, MODE_EXTRAP, 10'd2, 32'h8000_0000));
    push_req(make_req(CMD_LOAD, 32'd0, MODE_EXTRAP, 10'd3, 32'h0064_0000));
    push_req(make_req(CMD_LOAD, 32'd0, MODE_EXTRAP, 10'd4, 32'h7FFF_0000));
    push_req(make_req(CMD_LOAD, 32'hFFFF_FFFF, MODE_SPARE, 10'h3FF, 32'h1234_5678));
    // below the grid
    push_req(make_req(CMD_STEP, 32'hFFFF_FFFF, MODE_EXTRAP, 10'd0, 32'd0));
    push_req(make_req(CMD_STEP, 32'h8000_0000, MODE_EXTRAP, 10'd0, 32'd0));
    // rounding to nearest index, clamp to last entry, then two linear midpoints
    push_req(make_req(CMD_STEP, 32'd0, MODE_EXTRAP, 10'd0, 32'd0));
    push_req(make_req(CMD_STEP, 32'h0000_7FFF, MODE_EXTRAP, 10'd0, 32'd0));
    push_req(make_req(CMD_STEP, 32'h0000_8000, MODE_EXTRAP, 10'd0, 32'd0));
    push_req(make_req(CMD_STEP, 32'h7FFF_FFFF, MODE_EXTRAP, 10'd0, 32'd0));
    push_req(make_req(CMD_LINEAR, 32'h0000_8000, MODE_EXTRAP, 10'd0, 32'd0));
    push_req(make_req(CMD_LINEAR, 32'h0001_8000, MODE_EXTRAP, 10'd0, 32'd0));
    // at and beyond the grid end in each mode, then an unused command, a reload and more lookups
    push_req(make_req(CMD_LINEAR, 32'h0004_0000, MODE_ZERO, 10'd0, 32'd0));
    push_req(make_req(CMD_LINEAR, 32'h0005_0000, MODE_ZERO, 10'd0, 32'd0));
    push_req(make_req(CMD_LINEAR, 32'h0005_0000, MODE_LAST, 10'd0, 32'd0));
    push_req(make_req(CMD_LINEAR, 32'h0006_0000, MODE_EXTRAP, 10'd0, 32'd0));
    push_req(make_req(CMD_LINEAR, 32'h0006_0000, MODE_SPARE, 10'd0, 32'd0));
    push_req(make_req(CMD_LINEAR, 32'h7FFF_FFFF, MODE_EXTRAP, 10'd0, 32'd0));
    push_req(make_req(CMD_UNUSED, 32'h0001_0000, MODE_EXTRAP, 10'd1, 32'h5555_AAAA));
    push_req(make_req(CMD_LOAD, 32'd0, MODE_EXTRAP, 10'd4, 32'h8000_0000));
    push_req(make_req(CMD_LINEAR, 32'h0006_0000, MODE_EXTRAP, 10'd0, 32'd0));
    push_req(make_req(CMD_LINEAR, 32'hFFFF_FFFF, MODE_LAST, 10'd0, 32'd0));
    push_req(make_req(CMD_STEP, 32'h0003_0000, MODE_ZERO, 10'd0, 32'd0));
    wait_idle();
    for (int phase = 0; phase < 8; phase++) begin
      setup_phase(phase, count);
      @(negedge clk);
      repeat (count) push_req(rand_req());
      wait_idle();
    end
    if (lookup_results_due.size() != 0)
      report($sformatf("%0d lookups left without a result", lookup_results_due.size()));
    $display("run covered %0d loads and %0d lookups over %0d grid settings",
             loads_seen, lookups_seen, settings_count);
    $display("%0d results compared, %0d of them saturated, %0d mismatches",
             checked_count, sat_count, error_count);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
